>>> design/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg: shared codes and types for the bucket colormap
// Register indexes, gradient mode codes and the per-channel source selects
// that travel from the classifier to the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_BUCKETS   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GRADIENT_MODE = 2'd1;

	// Gradient mode codes; anything above MODE_SHSV means white
	localparam int MODE_BITS = 3;
	localparam logic [MODE_BITS-1:0] MODE_GREY = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_JET  = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_HOT  = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_HSV  = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_SHSV = 3'd4;

	localparam int NUM_BUCKETS_RESET = 256;
	localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_JET;

	// Segment or hue sector number inside a map
	localparam int SEG_BITS = 3;
	typedef logic [SEG_BITS-1:0] seg_t;

	localparam int QUEUE_DEPTH = 4;

	// Source of one output channel
	typedef enum logic [1:0] {
		CH_ZERO,  // 0.0
		CH_FULL,  // 1.0
		CH_QUOT,  // floor(num * FULL / den)
		CH_COMP   // floor((den - num) * FULL / den)
	} ch_sel_t;

	typedef struct packed {
		ch_sel_t red;
		ch_sel_t green;
		ch_sel_t blue;
	} rgb_sel_t;

endpackage

`default_nettype wire

>>> design/bcm_front.sv
// ----------------------------------------------------------------------------
// bcm_front: bucket classifier
// Clamps the bucket, finds the map segment and forms the divider job
// (numerator, denominator and channel selects) for the back end queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_front #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [INDEX_BITS-1:0]          num_buckets,
	input  wire logic [bcm_pkg::MODE_BITS-1:0]  gradient_mode,
	input  wire logic                           bucket_valid,
	output logic                                bucket_ready,
	input  wire logic [INDEX_BITS-1:0]          bucket,
	output logic                                job_valid,
	input  wire logic                           job_full,
	output logic [INDEX_BITS:0]                 job_num,
	output logic [INDEX_BITS:0]                 job_den,
	output bcm_pkg::rgb_sel_t                   job_sel
);
	import bcm_pkg::*;

	localparam int DW = INDEX_BITS + 1;
	localparam int MW = INDEX_BITS + 4;

	logic                  adv;
	logic [INDEX_BITS-1:0] n_eff;
	logic                  over;
	logic                  at_top;
	logic [MW-1:0]         nx;
	logic [MW-1:0]         bx;
	logic [MW-1:0]         n3_c, n5_c, n7_c, n9_c, b3_c;

	logic                  v_s1;
	logic [MODE_BITS-1:0]  mode_s1;
	logic [INDEX_BITS-1:0] c_s1;
	logic [MW-1:0]         c3_s1;
	logic                  wrap_s1;
	logic [INDEX_BITS-1:0] n_s1;
	logic [MW-1:0]         n3_s1, n5_s1, n7_s1, n9_s1;

	logic [MW-1:0]         n1_a, n2_a, n4_a, c8_a, c6_a;
	seg_t                  seg_c;

	logic                  v_s2;
	logic [MODE_BITS-1:0]  mode_s2;
	seg_t                  seg_s2;
	logic [INDEX_BITS-1:0] c_s2;
	logic [MW-1:0]         c3_s2, c6_s2;
	logic [INDEX_BITS-1:0] n_s2;
	logic [MW-1:0]         n3_s2, n5_s2, n7_s2, n9_s2;

	logic [MW-1:0]         n1_b, n2_b, n4_b, c8_b, hue_base, num_c;
	rgb_sel_t              sel_c;

	// Stall the whole front when the last stage cannot hand off
	assign adv          = !v_s2 || !job_full;
	assign bucket_ready = adv;

	// Stage 1: clamp and precompute multiples
	always_comb begin
		n_eff  = (num_buckets == '0) ? INDEX_BITS'(1) : num_buckets;
		over   = bucket > n_eff;
		at_top = bucket >= n_eff;
		nx     = MW'(n_eff);
		bx     = MW'(bucket);
		n3_c   = nx + (nx << 1);
		n5_c   = nx + (nx << 2);
		n7_c   = (nx << 3) - nx;
		n9_c   = (nx << 3) + nx;
		b3_c   = bx + (bx << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= bucket_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= gradient_mode;
			c_s1    <= over ? n_eff : bucket;
			c3_s1   <= over ? n3_c : b3_c;
			wrap_s1 <= at_top;
			n_s1    <= n_eff;
			n3_s1   <= n3_c;
			n5_s1   <= n5_c;
			n7_s1   <= n7_c;
			n9_s1   <= n9_c;
		end
	end

	// Stage 2: segment compares
	always_comb begin
		n1_a = MW'(n_s1);
		n2_a = n1_a << 1;
		n4_a = n1_a << 2;
		c8_a = MW'(c_s1) << 3;
		c6_a = wrap_s1 ? '0 : (c3_s1 << 1);
		seg_c = '0;
		unique case (mode_s1)
			MODE_JET: begin
				priority if (c8_a <= n1_a) seg_c = SEG_BITS'(0);
				else if (c8_a < n3_s1) seg_c = SEG_BITS'(1);
				else if (c8_a < n5_s1) seg_c = SEG_BITS'(2);
				else if (c8_a < n7_s1) seg_c = SEG_BITS'(3);
				else seg_c = SEG_BITS'(4);
			end
			MODE_HOT: begin
				priority if (c3_s1 <= n1_a) seg_c = SEG_BITS'(0);
				else if (c3_s1 <= n2_a) seg_c = SEG_BITS'(1);
				else seg_c = SEG_BITS'(2);
			end
			MODE_HSV, MODE_SHSV: begin
				priority if (c6_a >= n5_s1) seg_c = SEG_BITS'(5);
				else if (c6_a >= n4_a) seg_c = SEG_BITS'(4);
				else if (c6_a >= n3_s1) seg_c = SEG_BITS'(3);
				else if (c6_a >= n2_a) seg_c = SEG_BITS'(2);
				else if (c6_a >= n1_a) seg_c = SEG_BITS'(1);
				else seg_c = SEG_BITS'(0);
			end
			default: seg_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			seg_s2  <= seg_c;
			c_s2    <= c_s1;
			c3_s2   <= c3_s1;
			c6_s2   <= c6_a;
			n_s2    <= n_s1;
			n3_s2   <= n3_s1;
			n5_s2   <= n5_s1;
			n7_s2   <= n7_s1;
			n9_s2   <= n9_s1;
		end
	end

	// Job formation: at most one add or subtract forms the numerator
	always_comb begin
		n1_b     = MW'(n_s2);
		n2_b     = n1_b << 1;
		n4_b     = n1_b << 2;
		c8_b     = MW'(c_s2) << 3;
		hue_base = '0;
		num_c    = '0;
		sel_c    = '{red: CH_ZERO, green: CH_ZERO, blue: CH_ZERO};
		unique case (mode_s2)
			MODE_GREY: begin
				num_c = MW'(c_s2);
				sel_c = '{red: CH_QUOT, green: CH_QUOT, blue: CH_QUOT};
			end
			MODE_JET: begin
				unique case (seg_s2)
					SEG_BITS'(0): begin
						num_c      = n1_b + c8_b;
						sel_c.blue = CH_QUOT;
					end
					SEG_BITS'(1): begin
						num_c = c8_b - n1_b;
						sel_c = '{red: CH_ZERO, green: CH_QUOT, blue: CH_FULL};
					end
					SEG_BITS'(2): begin
						num_c = c8_b - n3_s2;
						sel_c = '{red: CH_QUOT, green: CH_FULL, blue: CH_COMP};
					end
					SEG_BITS'(3): begin
						num_c = n7_s2 - c8_b;
						sel_c = '{red: CH_FULL, green: CH_QUOT, blue: CH_ZERO};
					end
					default: begin
						num_c     = n9_s2 - c8_b;
						sel_c.red = CH_QUOT;
					end
				endcase
			end
			MODE_HOT: begin
				unique case (seg_s2)
					SEG_BITS'(0): begin
						num_c     = c3_s2;
						sel_c.red = CH_QUOT;
					end
					SEG_BITS'(1): begin
						num_c = c3_s2 - n1_b;
						sel_c = '{red: CH_FULL, green: CH_QUOT, blue: CH_ZERO};
					end
					default: begin
						num_c = c3_s2 - n2_b;
						sel_c = '{red: CH_FULL, green: CH_FULL, blue: CH_QUOT};
					end
				endcase
			end
			MODE_HSV, MODE_SHSV: begin
				unique case (seg_s2)
					SEG_BITS'(0): begin
						hue_base = '0;
						sel_c    = '{red: CH_FULL, green: CH_QUOT, blue: CH_ZERO};
					end
					SEG_BITS'(1): begin
						hue_base = n1_b;
						sel_c    = '{red: CH_COMP, green: CH_FULL, blue: CH_ZERO};
					end
					SEG_BITS'(2): begin
						hue_base = n2_b;
						sel_c    = '{red: CH_ZERO, green: CH_FULL, blue: CH_QUOT};
					end
					SEG_BITS'(3): begin
						hue_base = n3_s2;
						sel_c    = '{red: CH_ZERO, green: CH_COMP, blue: CH_FULL};
					end
					SEG_BITS'(4): begin
						hue_base = n4_b;
						sel_c    = '{red: CH_QUOT, green: CH_ZERO, blue: CH_FULL};
					end
					default: begin
						hue_base = n5_s2;
						sel_c    = '{red: CH_FULL, green: CH_ZERO, blue: CH_COMP};
					end
				endcase
				num_c = c6_s2 - hue_base;
			end
			default: begin
				num_c = '0;
				sel_c = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL};
			end
		endcase
	end

	assign job_valid = v_s2;
	assign job_num   = num_c[DW-1:0];
	assign job_den   = (mode_s2 == MODE_JET) ? {n_s2, 1'b0} : {1'b0, n_s2};
	assign job_sel   = sel_c;

	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (n_s1 != '0) && (c_s1 <= n_s1))
		else $error("clamped bucket outside 0..num_buckets");

endmodule

`default_nettype wire

>>> design/bcm_queue.sv
// ----------------------------------------------------------------------------
// bcm_queue: short job queue between classifier and divider
// Register-based FIFO; lets the front and back ends stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_queue #(
	parameter int WIDTH = 38
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);
	import bcm_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                push;
	logic                pop;

	assign full     = cnt_q == CNT_BITS'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && !full;
	assign pop      = rd_ready && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			if (push && !pop) cnt_q <= cnt_q + CNT_BITS'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q == rd_ptr_q) |-> (cnt_q == '0 || cnt_q == CNT_BITS'(QUEUE_DEPTH)))
		else $error("queue pointers and count disagree");

endmodule

`default_nettype wire

>>> design/bcm_back.sv
// ----------------------------------------------------------------------------
// bcm_back: divider back end
// Pipelined restoring divider, one quotient bit per stage, then channel
// assembly into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_back #(
	parameter int INDEX_BITS   = 16,
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    job_valid,
	output logic                         job_ready,
	input  wire logic [INDEX_BITS:0]     job_num,
	input  wire logic [INDEX_BITS:0]     job_den,
	input  wire bcm_pkg::rgb_sel_t       job_sel,
	output logic                         rgb_valid,
	input  wire logic                    rgb_ready,
	output logic [CHANNEL_BITS-1:0]      red,
	output logic [CHANNEL_BITS-1:0]      green,
	output logic [CHANNEL_BITS-1:0]      blue
);
	import bcm_pkg::*;

	localparam int CB = CHANNEL_BITS;
	localparam int DW = INDEX_BITS + 1;
	localparam int XW = DW + CB;
	localparam logic [CB-1:0] FULL = '1;

	logic          adv;
	logic [XW-1:0] x_c;

	logic          v_s   [CB+1];
	logic [DW-1:0] rem_s [CB+1];
	logic [DW-1:0] den_s [CB+1];
	logic [CB-1:0] xlo_s [CB+1];
	logic [CB-1:0] quo_s [CB+1];
	rgb_sel_t      sel_s [CB+1];

	logic          out_v_q;
	logic [CB-1:0] red_q, green_q, blue_q;
	logic [CB-1:0] comp_c;

	function automatic logic [CHANNEL_BITS-1:0] pick(ch_sel_t s, logic [CHANNEL_BITS-1:0] q,
			logic [CHANNEL_BITS-1:0] qc);
		logic [CHANNEL_BITS-1:0] r;
		unique case (s)
			CH_ZERO: r = '0;
			CH_FULL: r = '1;
			CH_QUOT: r = q;
			CH_COMP: r = qc;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign adv       = !out_v_q || rgb_ready;
	assign job_ready = adv;

	// Dividend num * FULL, as (num << CB) - num
	assign x_c = (XW'(job_num) << CB) - XW'(job_num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (adv) v_s[0] <= job_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= x_c[XW-1:CB];
			xlo_s[0] <= x_c[CB-1:0];
			den_s[0] <= job_den;
			quo_s[0] <= '0;
			sel_s[0] <= job_sel;
		end
	end

	for (genvar k = 0; k < CB; k++) begin : g_div
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[k], xlo_s[k][CB-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (adv) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
				xlo_s[k+1] <= xlo_s[k] << 1;
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][CB-2:0], ge};
				sel_s[k+1] <= sel_s[k];
			end
		end
	end

	// floor((den - num) * FULL / den) = FULL - ceil(num * FULL / den)
	assign comp_c = FULL - quo_s[CB] - CB'(rem_s[CB] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= v_s[CB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q   <= pick(sel_s[CB].red, quo_s[CB], comp_c);
			green_q <= pick(sel_s[CB].green, quo_s[CB], comp_c);
			blue_q  <= pick(sel_s[CB].blue, quo_s[CB], comp_c);
		end
	end

	assign rgb_valid = out_v_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> den_s[0] != '0)
		else $error("divider entered with zero denominator");

	a_num_le_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> rem_s[0] < den_s[0])
		else $error("divider numerator exceeds denominator");

endmodule

`default_nettype wire

>>> design/bucket_colormap_rgb.sv
// ----------------------------------------------------------------------------
// bucket_colormap_rgb: bucket index to RGB pseudo-color (grey/jet/hot/hsv)
// Throughput: one beat per cycle sustained, in and out, while rgb_ready is held high.
// Reset: arst_n clears all valid state and loads num_buckets = 256
//   (truncated to INDEX_BITS) and gradient_mode = jet.
// ----------------------------------------------------------------------------
`default_nettype none

module bucket_colormap_rgb #(
	parameter int INDEX_BITS   = 16,
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [bcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [INDEX_BITS-1:0]               cfg_wdata,
	// Bucket input channel
	input  wire logic                                bucket_valid,
	output logic                                     bucket_ready,
	input  wire logic [INDEX_BITS-1:0]               bucket,
	// Color output channel
	output logic                                     rgb_valid,
	input  wire logic                                rgb_ready,
	output logic [CHANNEL_BITS-1:0]                  red,
	output logic [CHANNEL_BITS-1:0]                  green,
	output logic [CHANNEL_BITS-1:0]                  blue
);
	import bcm_pkg::*;

	localparam int DW = INDEX_BITS + 1;
	localparam int QW = 2 * DW + $bits(rgb_sel_t);
	localparam logic [INDEX_BITS-1:0] NB_RESET = INDEX_BITS'(NUM_BUCKETS_RESET);

	// Configuration registers; the user must write them only while the block is idle (not enforced)
	logic [INDEX_BITS-1:0] num_buckets_q;
	logic [MODE_BITS-1:0]  gradient_mode_q;

	// Front end to queue
	logic                  fj_valid;
	logic                  fj_full;
	logic [DW-1:0]         fj_num;
	logic [DW-1:0]         fj_den;
	rgb_sel_t              fj_sel;

	// Queue to back end
	logic                  bj_valid;
	logic                  bj_ready;
	logic [QW-1:0]         bj_data;
	logic [DW-1:0]         bj_num;
	logic [DW-1:0]         bj_den;
	rgb_sel_t              bj_sel;

	// Decode config writes; writes to indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_buckets_q   <= NB_RESET;
			gradient_mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_BUCKETS:   num_buckets_q <= cfg_wdata;
				CFG_GRADIENT_MODE: gradient_mode_q <= cfg_wdata[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Front: clamp, classify into a map segment, build the division job.
	// Two pipeline stages; the job is pushed straight from the second one.
	bcm_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.num_buckets   (num_buckets_q),
		.gradient_mode (gradient_mode_q),
		.bucket_valid  (bucket_valid),
		.bucket_ready  (bucket_ready),
		.bucket        (bucket),
		.job_valid     (fj_valid),
		.job_full      (fj_full),
		.job_num       (fj_num),
		.job_den       (fj_den),
		.job_sel       (fj_sel)
	);

	// Queue: absorbs short stalls so the front keeps taking beats while the
	// output register holds a color that has not been taken yet.
	bcm_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fj_valid),
		.full     (fj_full),
		.wr_data  ({fj_num, fj_den, fj_sel}),
		.rd_valid (bj_valid),
		.rd_ready (bj_ready),
		.rd_data  (bj_data)
	);

	assign {bj_num, bj_den, bj_sel} = bj_data;

	// Back: every channel is FULL, zero, the quotient q = floor(num*FULL/den)
	// or its complement; one divider covers all three channels since the
	// only two fractional values in any map sum to one.
	bcm_back #(
		.INDEX_BITS   (INDEX_BITS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job_num   (bj_num),
		.job_den   (bj_den),
		.job_sel   (bj_sel),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bucket colormap
// Streams bucket indexes through the colormap under many settings of the
// bucket count and gradient mode. Each input and output beat follows a
// random gap, except in phases run back to back. A scoreboard class
// predicts each color and compares every returned channel in order.
// ----------------------------------------------------------------------------

module tb_top;

	import bcm_pkg::*;

	localparam int IDX_W = 16;
	localparam int CH_W  = 16;
	localparam longint unsigned FULL = (64'd1 << CH_W) - 1;
	localparam logic [CH_W-1:0] FULL_CH = '1;

	// No package code exists for white; every mode above shsv maps to it
	localparam logic [MODE_BITS-1:0] MODE_WHITE = 3'd5;

	// Idle cycles with no beat on either side before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// Cycles to keep watching the output after the last expected color
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// ------------------------------------------------------------------------
	// Scoreboard: its own copy of the two registers, a color predictor and
	// the queue of colors still owed by the block
	// ------------------------------------------------------------------------
	class colormap_board;
		logic [IDX_W-1:0]     num_buckets;
		logic [MODE_BITS-1:0] mode;
		rgb_t                 pending[$];
		int                   errors;

		function new();
			num_buckets = IDX_W'(NUM_BUCKETS_RESET);
			mode = MODE_RESET;
			errors = 0;
		endfunction

		function void configure(logic [IDX_W-1:0] n, logic [MODE_BITS-1:0] m);
			num_buckets = n;
			mode = m;
		endfunction

		// floor(num / den * FULL), saturated at FULL
		function logic [CH_W-1:0] frac(longint unsigned num, longint unsigned den);
			longint unsigned v;
			v = (num * FULL) / den;
			if (v > FULL)
				v = FULL;
			return v[CH_W-1:0];
		endfunction

		function rgb_t lookup(logic [IDX_W-1:0] bucket);
			longint unsigned n, c, c8, c3, two_n, sec, rem;
			logic [CH_W-1:0] f, nf;
			rgb_t o;
			n = 64'(num_buckets);
			if (n == 0)
				n = 1;  // zero bucket count acts as one
			c = 64'(bucket);
			if (c > n)
				c = n;  // clamp: anything past the end is t = 1
			c8 = 8 * c;
			c3 = 3 * c;
			two_n = 2 * n;
			o = '0;
			case (mode)
				MODE_GREY: begin
					o.red = frac(c, n);
					o.green = o.red;
					o.blue = o.red;
				end
				MODE_JET: begin
					// segment edges sit at t = 1/8, 3/8, 5/8, 7/8
					if (c8 <= n) begin
						o.blue = frac(n + c8, two_n);
					end else if (c8 < 3 * n) begin
						o.green = frac(c8 - n, two_n);
						o.blue = FULL_CH;
					end else if (c8 < 5 * n) begin
						o.red = frac(c8 - 3 * n, two_n);
						o.green = FULL_CH;
						o.blue = frac(5 * n - c8, two_n);
					end else if (c8 < 7 * n) begin
						o.red = FULL_CH;
						o.green = frac(7 * n - c8, two_n);
					end else begin
						// red falls from 1.0 to 0.5 over the last eighth
						o.red = frac(9 * n - c8, two_n);
					end
				end
				MODE_HOT: begin
					if (c3 <= n) begin
						o.red = frac(c3, n);
					end else if (c3 <= two_n) begin
						o.red = FULL_CH;
						o.green = frac(c3 - n, n);
					end else begin
						o.red = FULL_CH;
						o.green = FULL_CH;
						o.blue = frac(c3 - two_n, n);
					end
				end
				MODE_HSV, MODE_SHSV: begin
					if (c >= n)
						c = 0;  // hue 360 wraps to 0
					sec = (6 * c) / n;
					rem = 6 * c - sec * n;
					f = frac(rem, n);
					nf = frac(n - rem, n);
					case (sec)
						0: o = '{FULL_CH, f, '0};
						1: o = '{nf, FULL_CH, '0};
						2: o = '{'0, FULL_CH, f};
						3: o = '{'0, nf, FULL_CH};
						4: o = '{f, '0, FULL_CH};
						default: o = '{FULL_CH, '0, nf};
					endcase
				end
				default: begin
					o = '{FULL_CH, FULL_CH, FULL_CH};
				end
			endcase
			return o;
		endfunction

		function void note_bucket(logic [IDX_W-1:0] bucket);
			pending.push_back(lookup(bucket));
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR @%0t: %s", $realtime, msg);
		endtask

		task check_rgb(rgb_t got);
			rgb_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected color beat r=%h g=%h b=%h",
					got.red, got.green, got.blue));
			end else begin
				want = pending.pop_front();
				if (got.red !== want.red)
					report($sformatf("red %h, want %h", got.red, want.red));
				if (got.green !== want.green)
					report($sformatf("green %h, want %h", got.green, want.green));
				if (got.blue !== want.blue)
					report($sformatf("blue %h, want %h", got.blue, want.blue));
			end
		endtask

		function bit idle();
			return pending.size() == 0;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block inputs, all known from time zero
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [IDX_W-1:0]          cfg_wdata = '0;

	logic             bucket_valid = 1'b0;
	logic             bucket_ready;
	logic [IDX_W-1:0] bucket = '0;

	logic            rgb_valid;
	logic            rgb_ready = 1'b0;
	logic [CH_W-1:0] red, green, blue;

	// Back-to-back phases: when set, the matching side never idles
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	colormap_board sb = new();

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bucket_colormap_rgb #(
		.INDEX_BITS  (IDX_W),
		.CHANNEL_BITS(CH_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.bucket_valid(bucket_valid),
		.bucket_ready(bucket_ready),
		.bucket      (bucket),
		.rgb_valid   (rgb_valid),
		.rgb_ready   (rgb_ready),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	// ------------------------------------------------------------------------
	// Drivers; each is entered right after a rising edge
	// ------------------------------------------------------------------------

	// Offer one bucket beat after a random gap and hold it until taken.
	// Valid stays high across back-to-back beats and only drops for a gap.
	task send_bucket(logic [IDX_W-1:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			bucket_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bucket_valid <= 1'b1;
		bucket <= b;
		do @(posedge clk); while (!bucket_ready);
		sb.note_bucket(b);
	endtask

	// Drop valid and wait until every owed color has come back
	task settle();
		bucket_valid <= 1'b0;
		while (!sb.idle()) @(posedge clk);
	endtask

	// Write both registers, bucket count first and then mode; block must be idle
	task write_cfg(logic [IDX_W-1:0] n, logic [MODE_BITS-1:0] m);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_NUM_BUCKETS;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_index <= CFG_GRADIENT_MODE;
		cfg_wdata <= IDX_W'(m);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(n, m);
	endtask

	// Color sink: stall for a random gap before each beat, then take one
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				rgb_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rgb_ready <= 1'b1;
			do @(posedge clk); while (!rgb_valid);
			sb.check_rgb('{red, green, blue});
		end
	end

	// Watchdog: end the run if neither side moves a beat for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((bucket_valid && bucket_ready) || (rgb_valid && rgb_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat for %0d cycles", HANG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [IDX_W-1:0]     n;
		logic [MODE_BITS-1:0] m;
		logic [IDX_W-1:0]     b;
		int                   lim;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings (256 buckets, jet): ends, clamp and top index
		send_bucket(0);
		send_bucket(32);
		send_bucket(255);
		send_bucket(256);
		send_bucket(16'hffff);

		// 24 buckets puts every segment edge on a whole index
		write_cfg(24, MODE_JET);
		send_bucket(3);
		send_bucket(9);
		send_bucket(15);
		send_bucket(21);
		send_bucket(25);

		write_cfg(24, MODE_HOT);
		send_bucket(8);
		send_bucket(16);

		// Sector edges, plus hue 360 folding back to red
		write_cfg(24, MODE_HSV);
		send_bucket(4);
		send_bucket(8);
		send_bucket(12);
		send_bucket(16);
		send_bucket(20);
		send_bucket(24);

		write_cfg(24, MODE_SHSV);
		send_bucket(12);
		send_bucket(30);

		// Zero bucket count behaves as one
		write_cfg(0, MODE_GREY);
		send_bucket(0);
		send_bucket(1);

		write_cfg(24, MODE_WHITE);
		send_bucket(7);

		// Random phases: every mode code, bucket counts from the extremes to
		// random, buckets mostly inside the range with edges and overflow
		for (int ph = 0; ph < 24; ph++) begin
			case (ph)
				0: n = 1;
				1: n = 16'hffff;
				2: n = 0;
				default: begin
					case ($urandom_range(0, 6))
						0: n = IDX_W'($urandom_range(1, 3));
						1: n = IDX_W'($urandom_range(4, 40));
						2: n = IDX_W'(24 * $urandom_range(1, 60));
						3: n = IDX_W'($urandom_range(0, 16'hffff));
						4: n = IDX_W'(16'hffff - $urandom_range(0, 2));
						5: n = 256;
						default: n = IDX_W'($urandom_range(40, 1000));
					endcase
				end
			endcase
			m = (ph < 16) ? MODE_BITS'(ph) : MODE_BITS'($urandom_range(0, 4));
			write_cfg(n, m);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			lim = (n == '0) ? 1 : int'(n);
			for (int k = 0; k < 52; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: b = IDX_W'($urandom_range(0, lim));
					6: b = IDX_W'(lim + $urandom_range(0, 2));
					// land on or next to a multiple of n/24
					7: b = IDX_W'(($urandom_range(0, 24) * lim) / 24
						+ $urandom_range(0, 2) - 1);
					default: b = IDX_W'($urandom());
				endcase
				send_bucket(b);
			end
		end

		tx_burst = 1'b0;
		rx_burst = 1'b0;
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
